FILE: rtl/lru_key_value_cache_unit_macros.svh
// assertion macros for the lru key/value cache unit
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define LRUKV_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LRUKV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LRUKV_ASSERT(lbl, ante, cons, msg)
`define LRUKV_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/lrukv_pkg.sv
// shared types and constants for the lru key/value cache
`timescale 1ns / 1ps

package lrukv_pkg;

  // default sizes
  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_KEY_BITS    = 16;
  localparam int DEF_VALUE_BITS  = 32;

  // capacity register
  localparam int                CAP_W     = 5;
  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;

  // operation codes
  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_WRITE,
    ST_RESP
  } state_e;

  // write enables into the entry store
  typedef struct packed {
    logic key;
    logic val;
    logic rank;
  } store_we_t;

endpackage

FILE: rtl/lru_key_value_cache_unit.sv
// Fully associative key/value cache with least-recently-used replacement.
// A get miss walks the store once, a hit or a put twice; the store is walked one entry a cycle
// through its single read port, once to look up and once to age the recency ranks.
// One request at a time: a new request is taken only once the last result has been accepted.
// Reset: asynchronous, active low; all entries invalid, capacity 16, no clearing pass.
`timescale 1ns / 1ps
`include "lru_key_value_cache_unit_macros.svh"

module lru_key_value_cache_unit #(
  parameter int MAX_ENTRIES = lrukv_pkg::DEF_MAX_ENTRIES,
  parameter int KEY_BITS    = lrukv_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS  = lrukv_pkg::DEF_VALUE_BITS
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // capacity register write
  input  logic                                        cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  logic [lrukv_pkg::CAP_W-1:0]                 cfg_data_i,
  // request stream
  input  logic                                        s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // tdata: lookup_key, write_value (lowest bits first), zero padded
  input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]    s_axis_tdata_i,
  // tuser: func
  input  logic                                        s_axis_tuser_i,
  // result stream
  output logic                                        m_axis_tvalid_o,
  input  logic                                        m_axis_tready_i,
  // tdata: read_value, zero padded
  output logic [((VALUE_BITS+7)/8)*8-1:0]             m_axis_tdata_o,
  // tuser: hit, evicted (lowest bit first)
  output logic [1:0]                                  m_axis_tuser_o
);

  import lrukv_pkg::*;

  localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW  = (CW > CAP_W) ? CW : CAP_W;
  localparam int OUT_W = ((VALUE_BITS + 7) / 8) * 8;

  // control state
  state_e                  state_q, state_d;
  logic [CW-1:0]           addr_q, addr_d;
  logic                    s1_vld_q, s1_vld_d;
  logic [IW-1:0]           s1_idx_q, s1_idx_d;
  logic                    found_q, found_d;
  logic                    vic_q, vic_d;
  logic                    free_q, free_d;
  logic [MAX_ENTRIES-1:0]  valid_q, valid_d;
  logic [CW-1:0]           occ_q, occ_d;
  logic [CAP_W-1:0]        cap_q, cap_d;

  // request and working payload
  func_e                   func_q, func_d;
  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [VALUE_BITS-1:0]   val_q, val_d;
  logic [IW-1:0]           found_idx_q, found_idx_d;
  logic [IW-1:0]           found_rank_q, found_rank_d;
  logic [VALUE_BITS-1:0]   found_val_q, found_val_d;
  logic [IW-1:0]           vic_idx_q, vic_idx_d;
  logic [IW-1:0]           best_q, best_d;
  logic [IW-1:0]           free_idx_q, free_idx_d;
  logic [IW-1:0]           slot_q, slot_d;
  logic [IW-1:0]           limit_q, limit_d;
  logic                    limit_all_q, limit_all_d;
  logic                    ins_q, ins_d;
  logic                    hit_q, hit_d;
  logic                    evict_q, evict_d;
  logic [VALUE_BITS-1:0]   rd_value_q, rd_value_d;

  // store port signals
  logic [IW-1:0]           rd_addr;
  logic [IW-1:0]           wr_addr;
  store_we_t               we;
  logic [IW-1:0]           wr_rank;
  logic [KEY_BITS-1:0]     rd_key;
  logic [VALUE_BITS-1:0]   rd_val;
  logic [IW-1:0]           rd_rank;

  // shared magnitude comparator
  logic [IW-1:0]           cmp_a, cmp_b;
  logic                    cmp_lt;

  // capacity limit
  logic [CMPW-1:0]         cap_ext;
  logic [CMPW-1:0]         eff_cap;
  logic                    full;
  logic                    last_entry;
  logic                    s1_valid_bit;

  assign cmp_lt = cmp_a < cmp_b;

  // effective capacity: zero reads as one, clipped to the entry count
  always_comb begin
    cap_ext = CMPW'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(MAX_ENTRIES)) begin
      eff_cap = CMPW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full         = CMPW'(occ_q) >= eff_cap;
  assign last_entry   = s1_vld_q && (s1_idx_q == IW'(MAX_ENTRIES - 1));
  assign s1_valid_bit = valid_q[s1_idx_q];

  lrukv_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS),
    .IW          (IW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .we_i      (we),
    .wr_key_i  (key_q),
    .wr_val_i  (val_q),
    .wr_rank_i (wr_rank),
    .rd_key_o  (rd_key),
    .rd_val_o  (rd_val),
    .rd_rank_o (rd_rank)
  );

  // sequencer: next state and datapath control
  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    s1_vld_d     = 1'b0;
    s1_idx_d     = addr_q[IW-1:0];
    found_d      = found_q;
    vic_d        = vic_q;
    free_d       = free_q;
    valid_d      = valid_q;
    occ_d        = occ_q;
    cap_d        = cap_q;
    func_d       = func_q;
    key_d        = key_q;
    val_d        = val_q;
    found_idx_d  = found_idx_q;
    found_rank_d = found_rank_q;
    found_val_d  = found_val_q;
    vic_idx_d    = vic_idx_q;
    best_d       = best_q;
    free_idx_d   = free_idx_q;
    slot_d       = slot_q;
    limit_d      = limit_q;
    limit_all_d  = limit_all_q;
    ins_d        = ins_q;
    hit_d        = hit_q;
    evict_d      = evict_q;
    rd_value_d   = rd_value_q;
    rd_addr      = addr_q[IW-1:0];
    wr_addr      = s1_idx_q;
    we           = '0;
    wr_rank      = rd_rank + IW'(1);
    cmp_a        = best_q;
    cmp_b        = rd_rank;

    // capacity write
    if (cfg_valid_i) begin
      cap_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          func_d  = func_e'(s_axis_tuser_i);
          key_d   = s_axis_tdata_i[KEY_BITS-1:0];
          val_d   = s_axis_tdata_i[KEY_BITS +: VALUE_BITS];
          addr_d  = '0;
          found_d = 1'b0;
          vic_d   = 1'b0;
          free_d  = 1'b0;
          state_d = ST_SCAN;
        end
      end

      // walk all entries: first match, least recent valid, first free
      ST_SCAN: begin
        cmp_a = best_q;
        cmp_b = rd_rank;
        if (addr_q < CW'(MAX_ENTRIES)) begin
          s1_vld_d = 1'b1;
          addr_d   = addr_q + CW'(1);
        end
        if (s1_vld_q) begin
          if (s1_valid_bit && (rd_key == key_q) && !found_q) begin
            found_d      = 1'b1;
            found_idx_d  = s1_idx_q;
            found_rank_d = rd_rank;
            found_val_d  = rd_val;
          end
          if (s1_valid_bit && (!vic_q || cmp_lt)) begin
            vic_d     = 1'b1;
            vic_idx_d = s1_idx_q;
            best_d    = rd_rank;
          end
          if (!s1_valid_bit && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = s1_idx_q;
          end
          if (last_entry) begin
            state_d = ST_DECIDE;
          end
        end
      end

      // pick hit, insert slot or eviction
      ST_DECIDE: begin
        cmp_a       = free_idx_q;
        cmp_b       = vic_idx_q;
        addr_d      = '0;
        hit_d       = found_q;
        evict_d     = 1'b0;
        rd_value_d  = '0;
        ins_d       = 1'b0;
        limit_all_d = 1'b0;
        state_d     = ST_RESP;
        if (found_q) begin
          slot_d  = found_idx_q;
          limit_d = found_rank_q;
          if (func_q == FUNC_GET) begin
            rd_value_d = found_val_q;
          end
          state_d = ST_UPDATE;
        end else if (func_q == FUNC_PUT) begin
          if (full && vic_q) begin
            evict_d             = 1'b1;
            valid_d[vic_idx_q]  = 1'b0;
            slot_d              = (free_q && cmp_lt) ? free_idx_q : vic_idx_q;
            ins_d               = 1'b1;
            limit_all_d         = 1'b1;
            state_d             = ST_UPDATE;
          end else if (free_q) begin
            slot_d      = free_idx_q;
            occ_d       = occ_q + CW'(1);
            ins_d       = 1'b1;
            limit_all_d = 1'b1;
            state_d     = ST_UPDATE;
          end
        end
      end

      // age every valid entry more recent than the limit, or every valid entry on an insert
      ST_UPDATE: begin
        cmp_a = rd_rank;
        cmp_b = limit_q;
        if (addr_q < CW'(MAX_ENTRIES)) begin
          s1_vld_d = 1'b1;
          addr_d   = addr_q + CW'(1);
        end
        if (s1_vld_q) begin
          wr_addr = s1_idx_q;
          wr_rank = rd_rank + IW'(1);
          we.rank = s1_valid_bit && (s1_idx_q != slot_q) && (limit_all_q || cmp_lt);
          if (last_entry) begin
            state_d = ST_WRITE;
          end
        end
      end

      // slot becomes most recent; the value is stored on a put, the key on an insert
      ST_WRITE: begin
        wr_addr = slot_q;
        wr_rank = '0;
        we.rank = 1'b1;
        we.val  = (func_q == FUNC_PUT);
        we.key  = ins_q;
        if (ins_q) begin
          valid_d[slot_q] = 1'b1;
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      addr_q   <= '0;
      s1_vld_q <= 1'b0;
      found_q  <= 1'b0;
      vic_q    <= 1'b0;
      free_q   <= 1'b0;
      valid_q  <= '0;
      occ_q    <= '0;
      cap_q    <= CAP_RESET;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      s1_vld_q <= s1_vld_d;
      found_q  <= found_d;
      vic_q    <= vic_d;
      free_q   <= free_d;
      valid_q  <= valid_d;
      occ_q    <= occ_d;
      cap_q    <= cap_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s1_idx_q     <= s1_idx_d;
    func_q       <= func_d;
    key_q        <= key_d;
    val_q        <= val_d;
    found_idx_q  <= found_idx_d;
    found_rank_q <= found_rank_d;
    found_val_q  <= found_val_d;
    vic_idx_q    <= vic_idx_d;
    best_q       <= best_d;
    free_idx_q   <= free_idx_d;
    slot_q       <= slot_d;
    limit_q      <= limit_d;
    limit_all_q  <= limit_all_d;
    ins_q        <= ins_d;
    hit_q        <= hit_d;
    evict_q      <= evict_d;
    rd_value_q   <= rd_value_d;
  end

  // ports
  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_RESP);
  assign m_axis_tdata_o  = OUT_W'(rd_value_q);
  assign m_axis_tuser_o  = {evict_q, hit_q};

  // checks
  `LRUKV_ASSERT(a_occ_in_range, 1'b1, occ_q <= CW'(MAX_ENTRIES),
                "occupancy above entry count")
  `LRUKV_ASSERT(a_occ_matches_valid, state_q == ST_IDLE,
                $countones(valid_q) == int'(occ_q), "occupancy out of step with valid bits")
  `LRUKV_ASSERT(a_hit_excludes_evict, m_axis_tvalid_o,
                !(m_axis_tuser_o[0] && m_axis_tuser_o[1]), "hit and eviction in one result")
  `LRUKV_ASSERT_NXT(a_busy_after_request, s_axis_tvalid_i && s_axis_tready_o,
                    !s_axis_tready_o, "new request taken while busy")

endmodule

FILE: rtl/lrukv_store.sv
// entry store: keys, values and recency ranks, one read and one write port
`timescale 1ns / 1ps

module lrukv_store #(
  parameter int MAX_ENTRIES = lrukv_pkg::DEF_MAX_ENTRIES,
  parameter int KEY_BITS    = lrukv_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS  = lrukv_pkg::DEF_VALUE_BITS,
  parameter int IW          = 4
) (
  input  logic                  clk_i,
  input  logic [IW-1:0]         rd_addr_i,
  input  logic [IW-1:0]         wr_addr_i,
  input  lrukv_pkg::store_we_t  we_i,
  input  logic [KEY_BITS-1:0]   wr_key_i,
  input  logic [VALUE_BITS-1:0] wr_val_i,
  input  logic [IW-1:0]         wr_rank_i,
  output logic [KEY_BITS-1:0]   rd_key_o,
  output logic [VALUE_BITS-1:0] rd_val_o,
  output logic [IW-1:0]         rd_rank_o
);

  import lrukv_pkg::*;

  logic [KEY_BITS-1:0]   keys_mem  [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] vals_mem  [MAX_ENTRIES];
  logic [IW-1:0]         ranks_mem [MAX_ENTRIES];

  logic [KEY_BITS-1:0]   rd_key_q;
  logic [VALUE_BITS-1:0] rd_val_q;
  logic [IW-1:0]         rd_rank_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i.key) begin
      keys_mem[wr_addr_i] <= wr_key_i;
    end
    if (we_i.val) begin
      vals_mem[wr_addr_i] <= wr_val_i;
    end
    if (we_i.rank) begin
      ranks_mem[wr_addr_i] <= wr_rank_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_key_q  <= keys_mem[rd_addr_i];
    rd_val_q  <= vals_mem[rd_addr_i];
    rd_rank_q <= ranks_mem[rd_addr_i];
  end

  assign rd_key_o  = rd_key_q;
  assign rd_val_o  = rd_val_q;
  assign rd_rank_o = rd_rank_q;

endmodule
